@@ sv/lattice_walk_collision_check_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LATTICE_WALK_COLLISION_CHECK_CORE_DEFINES_SVH
`define LATTICE_WALK_COLLISION_CHECK_CORE_DEFINES_SVH

// Same-cycle implication under reset.
`define LWCC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lwcc assertion failed");

// Next-cycle implication under reset.
`define LWCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lwcc assertion failed");

`endif

@@ sv/lwcc_pkg.sv @@
package lwcc_pkg;

    localparam int DEF_CHAIN_DEPTH = 1024;
    localparam int DEF_COORD_BITS  = 16;

    localparam int INDEX_BITS   = 10;
    localparam int SCAN_BITS    = INDEX_BITS + 1;
    localparam int NUM_POS      = 9;
    localparam int FIELD_BITS   = 16;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 8;
    localparam int MOVE_TABLE_W = 48;
    localparam int CONT_TABLE_W = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic CFG_MOVE_TABLE = 1'b0;
    localparam logic CFG_CONT_TABLE = 1'b1;

    localparam logic [1:0] LOOK_BEAD = 2'd0;
    localparam logic [1:0] LOOK_ONE  = 2'd1;

    localparam int FIRST_BACK_BEAD = 6;
    localparam int FIRST_BACK_ONE  = 5;
    localparam int FIRST_BACK_TWO  = 4;
    localparam int SCAN_STRIDE     = 2;

    typedef struct packed {
        logic signed [2:0] dx;
        logic signed [2:0] dy;
        logic signed [2:0] dz;
    } offset_t;

    function automatic logic signed [1:0] move_comp(
        input logic [MOVE_TABLE_W-1:0] tbl,
        input logic                    half,
        input logic [1:0]              mv,
        input int                      axis
    );
        int idx;
        idx = ((int'(half) * 4 + int'(mv)) * 3 + axis) * 2;
        return signed'(tbl[idx +: 2]);
    endfunction

    function automatic logic [1:0] next_move(
        input logic [CONT_TABLE_W-1:0] tbl,
        input logic [1:0]              last,
        input int                      t
    );
        int idx;
        idx = (int'(last) * 3 + t) * 2;
        return tbl[idx +: 2];
    endfunction

endpackage

@@ sv/lwcc_offset_gen.sv @@
module lwcc_offset_gen
    import lwcc_pkg::*;
(
    input  logic [MOVE_TABLE_W-1:0] move_table,
    input  logic [CONT_TABLE_W-1:0] cont_table,
    input  logic [1:0]              lookahead,
    input  logic [1:0]              last_move,
    input  logic                    parity,
    output offset_t                 offsets [NUM_POS],
    output logic [NUM_POS-1:0]      pos_valid
);

    always_comb begin
        logic [1:0]        m1;
        logic [1:0]        m2;
        logic signed [2:0] c1 [3];
        logic signed [2:0] c2 [3];
        m1 = '0;
        m2 = '0;
        for (int a = 0; a < 3; a++) begin
            c1[a] = '0;
            c2[a] = '0;
        end
        for (int k = 0; k < NUM_POS; k++) begin
            offsets[k] = '0;
        end
        pos_valid = '0;
        case (lookahead)
            LOOK_BEAD: begin
                pos_valid[0] = 1'b1;
            end
            LOOK_ONE: begin
                for (int i = 0; i < 3; i++) begin
                    m1 = next_move(cont_table, last_move, i);
                    offsets[i].dx = 3'(move_comp(move_table, ~parity, m1, 0));
                    offsets[i].dy = 3'(move_comp(move_table, ~parity, m1, 1));
                    offsets[i].dz = 3'(move_comp(move_table, ~parity, m1, 2));
                    pos_valid[i]  = 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    m1 = next_move(cont_table, last_move, i);
                    for (int a = 0; a < 3; a++) begin
                        c1[a] = 3'(move_comp(move_table, ~parity, m1, a));
                    end
                    for (int j = 0; j < 3; j++) begin
                        m2 = next_move(cont_table, m1, j);
                        for (int a = 0; a < 3; a++) begin
                            c2[a] = 3'(move_comp(move_table, parity, m2, a));
                        end
                        offsets[i*3+j].dx = c1[0] + c2[0];
                        offsets[i*3+j].dy = c1[1] + c2[1];
                        offsets[i*3+j].dz = c1[2] + c2[2];
                        pos_valid[i*3+j]  = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

@@ sv/lwcc_bead_store.sv @@
module lwcc_bead_store
    import lwcc_pkg::*;
#(
    parameter int DEPTH = DEF_CHAIN_DEPTH,
    parameter int WIDTH = 3 * DEF_COORD_BITS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/lwcc_match_unit.sv @@
module lwcc_match_unit
    import lwcc_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic [3*COORD_BITS-1:0] head,
    input  logic [3*COORD_BITS-1:0] bead,
    input  offset_t                 offsets [NUM_POS],
    input  logic [NUM_POS-1:0]      pos_valid,
    output logic                    hit
);

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0] delta [3];
    logic [NUM_POS-1:0]   pos_hit;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            delta[a] = DW'(signed'(bead[a*COORD_BITS +: COORD_BITS]))
                     - DW'(signed'(head[a*COORD_BITS +: COORD_BITS]));
        end
        for (int k = 0; k < NUM_POS; k++) begin
            pos_hit[k] = pos_valid[k]
                       && (delta[0] == DW'(offsets[k].dx))
                       && (delta[1] == DW'(offsets[k].dy))
                       && (delta[2] == DW'(offsets[k].dz));
        end
    end

    assign hit = |pos_hit;

endmodule

@@ sv/lattice_walk_collision_check_core.sv @@
// Lattice walk collision check.
// Input words (s_ channel) either store one bead triple (tuser op = write)
// or run one overlap check on the bead at bead_index (tuser op = check).
// Configuration words (cfg_ channel) load the move table (index 0) and the
// continuation table (index 1); cfg_ready is always high.
// A write returns nothing; s_tready stays high.
// A check holds s_tready low through the head read, the load, the scan of
// the earlier beads (every second one, down to lower_bound, at most about 510)
// and the finish state, since the scan reads one bead from the store per
// cycle through a single read port and one shared compare unit tests it
// against all candidate positions; a hit ends the scan early, and a check
// that scans nothing goes straight to the finish state. The result word
// (m_tdata bit 0 = collision) then waits in an output register; new words
// are accepted meanwhile. If m_tready stays low, a second check finishes
// its scan and then holds until the slot frees.
// Reset clears the tables, the sequencer and the output valid flag; the
// bead store keeps no reset value and must be written before it is read.
module lattice_walk_collision_check_core
    import lwcc_pkg::*;
#(
    parameter int CHAIN_DEPTH = DEF_CHAIN_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // bead_index, coord_x, coord_y, coord_z, lookahead, last_move, parity, lower_bound
    input  logic [S_TDATA_W-1:0]    s_tdata,
    // op
    input  logic [0:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // collision
    output logic [M_TDATA_W-1:0]    m_tdata,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [0:0]              cfg_index,
    input  logic [MOVE_TABLE_W-1:0] cfg_data
);

    localparam int AW = $clog2(CHAIN_DEPTH);
    localparam int EW = AW + INDEX_BITS;
    localparam int BW = 3 * COORD_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HEAD = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [INDEX_BITS-1:0] in_index;
    logic [FIELD_BITS-1:0] in_x;
    logic [FIELD_BITS-1:0] in_y;
    logic [FIELD_BITS-1:0] in_z;
    logic [1:0]            in_look;
    logic [1:0]            in_last;
    logic                  in_parity;
    logic [INDEX_BITS-1:0] in_lb;

    assign in_index  = s_tdata[9:0];
    assign in_x      = s_tdata[25:10];
    assign in_y      = s_tdata[41:26];
    assign in_z      = s_tdata[57:42];
    assign in_look   = s_tdata[59:58];
    assign in_last   = s_tdata[61:60];
    assign in_parity = s_tdata[62];
    assign in_lb     = s_tdata[72:63];

    logic [MOVE_TABLE_W-1:0] move_table_reg;
    logic [CONT_TABLE_W-1:0] cont_table_reg;

    logic [2:0]                   state_reg, state_next;
    logic [INDEX_BITS-1:0]        bi_reg, bi_next;
    logic signed [SCAN_BITS-1:0]  scan_reg, scan_next;
    logic [INDEX_BITS-1:0]        lb_reg, lb_next;
    offset_t                      ofs_reg [NUM_POS];
    logic [NUM_POS-1:0]           pv_reg;
    logic [BW-1:0]                head_reg;
    logic                         result_reg, result_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_data_reg, out_data_next;

    offset_t            gen_ofs [NUM_POS];
    logic [NUM_POS-1:0] gen_pv;
    logic               accept;
    logic               in_range;
    logic signed [SCAN_BITS-1:0] first_idx;
    logic               scan_empty;
    logic               scan_more;
    logic               out_free;
    logic               hit;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [BW-1:0]      wr_data;
    logic [BW-1:0]      rd_data;
    logic [EW-1:0]      wr_ext;
    logic [EW-1:0]      rd_ext;
    logic [INDEX_BITS-1:0] rd_index;
    logic signed [31:0] wx, wy, wz;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_data_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign in_range  = (32'(in_index) < 32'(CHAIN_DEPTH));

    lwcc_offset_gen u_ofs (
        .move_table (move_table_reg),
        .cont_table (cont_table_reg),
        .lookahead  (in_look),
        .last_move  (in_last),
        .parity     (in_parity),
        .offsets    (gen_ofs),
        .pos_valid  (gen_pv)
    );

    always_comb begin
        case (in_look)
            LOOK_BEAD: first_idx = signed'({1'b0, in_index}) - SCAN_BITS'(FIRST_BACK_BEAD);
            LOOK_ONE:  first_idx = signed'({1'b0, in_index}) - SCAN_BITS'(FIRST_BACK_ONE);
            default:   first_idx = signed'({1'b0, in_index}) - SCAN_BITS'(FIRST_BACK_TWO);
        endcase
    end

    assign scan_empty = (first_idx < signed'({1'b0, in_lb}));
    assign scan_more  = (scan_reg >= signed'({1'b0, lb_reg}));

    // write side of the bead store
    assign wx      = 32'(signed'(in_x));
    assign wy      = 32'(signed'(in_y));
    assign wz      = 32'(signed'(in_z));
    assign wr_data = {wz[COORD_BITS-1:0], wy[COORD_BITS-1:0], wx[COORD_BITS-1:0]};
    assign wr_en   = accept && (s_tuser[0] == OP_WRITE) && in_range;
    assign wr_ext  = EW'(in_index);
    assign wr_addr = wr_ext[AW-1:0];

    assign rd_index = (state_reg == ST_HEAD) ? bi_reg : scan_reg[INDEX_BITS-1:0];
    assign rd_ext   = EW'(rd_index);
    assign rd_addr  = rd_ext[AW-1:0];

    lwcc_bead_store #(
        .DEPTH (CHAIN_DEPTH),
        .WIDTH (BW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lwcc_match_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_match (
        .head      (head_reg),
        .bead      (rd_data),
        .offsets   (ofs_reg),
        .pos_valid (pv_reg),
        .hit       (hit)
    );

    always_comb begin
        state_next     = state_reg;
        bi_next        = bi_reg;
        scan_next      = scan_reg;
        lb_next        = lb_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser[0] == OP_CHECK)) begin
                    bi_next     = in_index;
                    scan_next   = first_idx;
                    lb_next     = in_lb;
                    result_next = 1'b0;
                    if (!in_range || scan_empty) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                scan_next  = scan_reg - SCAN_BITS'(SCAN_STRIDE);
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    result_next = 1'b1;
                    state_next  = ST_FIN;
                end else if (scan_more) begin
                    scan_next = scan_reg - SCAN_BITS'(SCAN_STRIDE);
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            move_table_reg <= '0;
            cont_table_reg <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index[0])
                    CFG_MOVE_TABLE: move_table_reg <= cfg_data;
                    CFG_CONT_TABLE: cont_table_reg <= cfg_data[CONT_TABLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        bi_reg       <= bi_next;
        scan_reg     <= scan_next;
        lb_reg       <= lb_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
        if (accept) begin
            ofs_reg <= gen_ofs;
            pv_reg  <= gen_pv;
        end
        if (state_reg == ST_LOAD) begin
            head_reg <= rd_data;
        end
    end

endmodule

@@ sv/lwcc_checker.sv @@
`include "lattice_walk_collision_check_core_defines.svh"

module lwcc_checker
    import lwcc_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [S_TDATA_W-1:0]    s_tdata,
    input logic [0:0]              s_tuser,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_W-1:0]    m_tdata,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic [0:0]              cfg_index,
    input logic [MOVE_TABLE_W-1:0] cfg_data
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    `LWCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LWCC_ASSERT_NEXT(a_check_busy, aclk, aresetn, s_acc && (s_tuser[0] == OP_CHECK), !s_tready)
    `LWCC_ASSERT_NEXT(a_write_free, aclk, aresetn, s_acc && (s_tuser[0] == OP_WRITE), s_tready)
    `LWCC_ASSERT_NOW(a_out_pad, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:1] == '0)

endmodule

bind lattice_walk_collision_check_core lwcc_checker u_lwcc_checker (.*);

@@ verif/testbench.sv @@
module testbench;
    import lwcc_pkg::*;

    localparam logic [1:0] LOOK_TWO  = 2'd2;
    localparam logic [1:0] LOOK_WIDE = 2'd3;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PHASES       = 6;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 32;

    typedef struct {
        logic                         op;
        logic [INDEX_BITS-1:0]        bead;
        logic signed [FIELD_BITS-1:0] cx;
        logic signed [FIELD_BITS-1:0] cy;
        logic signed [FIELD_BITS-1:0] cz;
        logic [1:0]                   look;
        logic [1:0]                   last;
        logic                         par;
        logic [INDEX_BITS-1:0]        lb;
    } bead_word_t;

    class collision_scoreboard;
        logic [MOVE_TABLE_W-1:0]      move_tab;
        logic [CONT_TABLE_W-1:0]      cont_tab;
        logic signed [FIELD_BITS-1:0] bead_x [DEF_CHAIN_DEPTH];
        logic signed [FIELD_BITS-1:0] bead_y [DEF_CHAIN_DEPTH];
        logic signed [FIELD_BITS-1:0] bead_z [DEF_CHAIN_DEPTH];
        bit                           filled [DEF_CHAIN_DEPTH];
        bit                           expected_hits [$];
        int                           errors;
        int                           writes;
        int                           checks;
        int                           results;
        int                           hits;

        function new();
            move_tab = '0;
            cont_tab = '0;
        endfunction

        function void load_table(logic idx, logic [MOVE_TABLE_W-1:0] data);
            if (idx == CFG_MOVE_TABLE) begin
                move_tab = data;
            end else begin
                cont_tab = data[CONT_TABLE_W-1:0];
            end
        endfunction

        function int move_delta(logic half, logic [1:0] mv, int axis);
            logic [1:0] b;
            b = move_tab[2 * ((int'(half) * 4 + int'(mv)) * 3 + axis) +: 2];
            return b[1] ? int'(b) - 4 : int'(b);
        endfunction

        function logic [1:0] follow_move(logic [1:0] last, int t);
            return cont_tab[2 * (int'(last) * 3 + t) +: 2];
        endfunction

        function int first_back(logic [1:0] look);
            case (look)
                LOOK_BEAD: return FIRST_BACK_BEAD;
                LOOK_ONE:  return FIRST_BACK_ONE;
                default:   return FIRST_BACK_TWO;
            endcase
        endfunction

        function bit scan_safe(bead_word_t w);
            int t;
            if (!filled[w.bead]) return 0;
            for (t = int'(w.bead) - first_back(w.look); t >= int'(w.lb) && t >= 0;
                 t -= SCAN_STRIDE) begin
                if (!filled[t]) return 0;
            end
            return 1;
        endfunction

        function bit predict_collision(bead_word_t w);
            int px [NUM_POS];
            int py [NUM_POS];
            int pz [NUM_POS];
            int n, i, j, k, t, bx, by, bz;
            logic [1:0] m1, m2;
            bx = bead_x[w.bead];
            by = bead_y[w.bead];
            bz = bead_z[w.bead];
            n = 0;
            if (w.look == LOOK_BEAD) begin
                px[0] = bx;
                py[0] = by;
                pz[0] = bz;
                n = 1;
            end else begin
                for (i = 0; i < 3; i++) begin
                    m1 = follow_move(w.last, i);
                    if (w.look == LOOK_ONE) begin
                        px[n] = bx + move_delta(!w.par, m1, 0);
                        py[n] = by + move_delta(!w.par, m1, 1);
                        pz[n] = bz + move_delta(!w.par, m1, 2);
                        n++;
                    end else begin
                        for (j = 0; j < 3; j++) begin
                            m2 = follow_move(m1, j);
                            px[n] = bx + move_delta(!w.par, m1, 0) + move_delta(w.par, m2, 0);
                            py[n] = by + move_delta(!w.par, m1, 1) + move_delta(w.par, m2, 1);
                            pz[n] = bz + move_delta(!w.par, m1, 2) + move_delta(w.par, m2, 2);
                            n++;
                        end
                    end
                end
            end
            for (t = int'(w.bead) - first_back(w.look); t >= int'(w.lb) && t >= 0;
                 t -= SCAN_STRIDE) begin
                for (k = 0; k < n; k++) begin
                    if (px[k] == bead_x[t] && py[k] == bead_y[t] && pz[k] == bead_z[t])
                        return 1;
                end
            end
            return 0;
        endfunction

        function void note_word(bead_word_t w);
            if (w.op == OP_WRITE) begin
                bead_x[w.bead] = w.cx;
                bead_y[w.bead] = w.cy;
                bead_z[w.bead] = w.cz;
                filled[w.bead] = 1;
                writes++;
            end else begin
                expected_hits.push_back(predict_collision(w));
                checks++;
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        task report_mismatch(string what);
            if (errors < 50) $display("MISMATCH: %s", what);
            errors++;
        endtask

        task check_result(logic hit);
            bit want;
            if (expected_hits.size() == 0) begin
                report_mismatch($sformatf("collision word %0b with no check pending", hit));
                return;
            end
            want = expected_hits.pop_front();
            if (hit !== want)
                report_mismatch($sformatf("check %0d: collision %0b, want %0b",
                                          results, hit, want));
            results++;
            if (want) hits++;
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic [0:0]              s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [0:0]              cfg_index = '0;
    logic [MOVE_TABLE_W-1:0] cfg_data  = '0;

    collision_scoreboard sb = new();
    bit calm = 0;
    int sent = 0;
    int idle_cycles = 0;

    lattice_walk_collision_check_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata[0]);
        m_tready <= calm || ($urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_word(bead_word_t w);
        while (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, w.lb, w.par, w.last, w.look, w.cz, w.cy, w.cx, w.bead};
        s_tuser  <= w.op;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
        sent++;
    endtask

    task automatic write_bead(int idx, int x, int y, int z);
        bead_word_t w;
        w.op   = OP_WRITE;
        w.bead = INDEX_BITS'(idx);
        w.cx   = FIELD_BITS'(x);
        w.cy   = FIELD_BITS'(y);
        w.cz   = FIELD_BITS'(z);
        w.look = 2'($urandom);
        w.last = 2'($urandom);
        w.par  = 1'($urandom);
        w.lb   = INDEX_BITS'($urandom);
        send_word(w);
    endtask

    function automatic bead_word_t make_check(int idx, logic [1:0] look, logic [1:0] last,
                                              logic par, int lb);
        bead_word_t w;
        w.op   = OP_CHECK;
        w.bead = INDEX_BITS'(idx);
        w.cx   = FIELD_BITS'($urandom);
        w.cy   = FIELD_BITS'($urandom);
        w.cz   = FIELD_BITS'($urandom);
        w.look = look;
        w.last = last;
        w.par  = par;
        w.lb   = INDEX_BITS'(lb);
        return w;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic load_tables(logic [MOVE_TABLE_W-1:0] mv, logic [MOVE_TABLE_W-1:0] ct);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MOVE_TABLE;
        cfg_data  <= mv;
        do @(posedge aclk); while (!cfg_ready);
        sb.load_table(CFG_MOVE_TABLE, mv);
        cfg_index <= CFG_CONT_TABLE;
        cfg_data  <= ct;
        do @(posedge aclk); while (!cfg_ready);
        sb.load_table(CFG_CONT_TABLE, ct);
        cfg_valid <= 1'b0;
    endtask

    function automatic int start_coord();
        case ($urandom_range(3))
            0:       return 32767 - int'($urandom_range(3));
            1:       return -32768 + int'($urandom_range(3));
            default: return int'($urandom_range(40)) - 20;
        endcase
    endfunction

    // grow a walk along the configured moves, checking the newest bead as it goes
    task automatic grow_walk(int len);
        int base, px, py, pz, k, j, lbv;
        logic [1:0] mv, last;
        logic p, p0;
        bead_word_t w;
        base = $urandom_range(DEF_CHAIN_DEPTH - len);
        px   = start_coord();
        py   = start_coord();
        pz   = start_coord();
        last = 2'($urandom);
        p0   = 1'($urandom);
        write_bead(base, px, py, pz);
        for (k = 1; k < len; k++) begin
            p  = p0 ^ k[0];
            mv = sb.follow_move(last, $urandom_range(2));
            if ($urandom_range(99) < 8) begin
                // fold back onto an earlier bead
                j  = base + $urandom_range(k - 1);
                px = sb.bead_x[j];
                py = sb.bead_y[j];
                pz = sb.bead_z[j];
            end else begin
                px += sb.move_delta(p, mv, 0);
                py += sb.move_delta(p, mv, 1);
                pz += sb.move_delta(p, mv, 2);
            end
            last = mv;
            write_bead(base + k, px, py, pz);
            if ($urandom_range(99) < 45) begin
                lbv = base + $urandom_range(k);
                if ($urandom_range(99) < 10) lbv = $urandom_range(base);
                w = make_check(base + k, 2'($urandom), last,
                               ($urandom_range(99) < 90) ? p : 1'($urandom), lbv);
                if (!sb.scan_safe(w)) w.lb = INDEX_BITS'(base);
                send_word(w);
            end
        end
    endtask

    task automatic random_noise();
        int bi, lbv;
        bead_word_t w;
        bi = $urandom_range(DEF_CHAIN_DEPTH - 1);
        if ($urandom_range(1) == 0 || !sb.filled[bi]) begin
            write_bead(bi, $urandom, $urandom, $urandom);
        end else begin
            w = make_check(bi, 2'($urandom), 2'($urandom), 1'($urandom),
                           $urandom_range(DEF_CHAIN_DEPTH - 1));
            if (!sb.scan_safe(w)) begin
                lbv  = bi - int'($urandom_range(30));
                w.lb = INDEX_BITS'((lbv < 0) ? 0 : lbv);
            end
            if (!sb.scan_safe(w)) w.lb = INDEX_BITS'(bi);
            send_word(w);
        end
    endtask

    initial begin : stimulus
        logic [MOVE_TABLE_W-1:0] mv, ct;
        int ph, k, goal, mid, len;
        bit paused;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // half 0 moves all +1, half 1 all -2
        load_tables(48'hAAAAAA_555555, 48'h000000_E4E4E4);
        write_bead(0, -32768, -32768, -32768);
        write_bead(1, 32767, -1, 0);
        write_bead(2, 0, 0, 0);
        write_bead(3, -1, -1, -1);
        write_bead(4, 1, 1, 1);
        write_bead(5, 32767, 32767, 32767);
        write_bead(6, -32768, -32768, -32768);
        write_bead(7, 5, -7, 3);
        write_bead(1023, 32767, -32768, -1);
        send_word(make_check(6, LOOK_BEAD, 2'd0, 1'b0, 0));
        send_word(make_check(6, LOOK_BEAD, 2'd1, 1'b1, 1));
        send_word(make_check(5, LOOK_ONE, 2'd0, 1'b1, 0));
        send_word(make_check(7, LOOK_ONE, 2'd1, 1'b0, 0));
        send_word(make_check(6, LOOK_TWO, 2'd2, 1'b0, 0));
        send_word(make_check(7, LOOK_WIDE, 2'd3, 1'b1, 1));
        send_word(make_check(4, LOOK_TWO, 2'd0, 1'b1, 0));
        send_word(make_check(7, LOOK_BEAD, 2'd2, 1'b0, 0));
        send_word(make_check(1023, LOOK_BEAD, 2'd3, 1'b1, 1023));

        for (ph = 0; ph < PHASES; ph++) begin
            ct = {16'($urandom), $urandom()};
            case (ph)
                1: begin
                    mv = '0;
                    ct = '0;
                end
                2: begin
                    mv = '1;
                    ct = '1;
                end
                3: for (k = 0; k < MOVE_TABLE_W / 2; k++)
                    mv[2 * k +: 2] = (k % 3 == 0) ? 2'b11 : 2'($urandom_range(1));
                4: mv = {24{2'b10}};
                default: mv = {16'($urandom), $urandom()};
            endcase
            load_tables(mv, ct);
            calm   = (ph == 2);
            goal   = sent + RANDOM_ITEMS / PHASES;
            mid    = sent + RANDOM_ITEMS / (2 * PHASES);
            paused = 0;
            while (sent < goal) begin
                if (!paused && sent >= mid) begin
                    wait_drained();
                    paused = 1;
                end
                if ($urandom_range(99) < 20) begin
                    random_noise();
                end else begin
                    len = ($urandom_range(11) == 0) ? $urandom_range(100, 250)
                                                    : $urandom_range(6, 40);
                    if (len > goal - sent) len = goal - sent;
                    grow_walk(len);
                end
            end
        end
        calm = 0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d checks never answered", sb.pending()));
        $display("Covered %0d bead writes and %0d overlap checks (%0d hits) under %0d table sets,",
                 sb.writes, sb.checks, sb.hits, PHASES + 1);
        $display("with walks folding back on themselves, far-edge coordinates and random stalls.");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
